@@ rtl/frcc_pkg.sv @@
package frcc_pkg;

  localparam int unsigned MAX_RECORD_WORDS = 131072;
  localparam int unsigned IDX_W = $clog2(MAX_RECORD_WORDS) + 1;
  localparam int unsigned MIN_RECORD_WORDS = 4;
  localparam int unsigned KIND_W = 8;
  localparam int unsigned WORD_W = 64;

  localparam logic [WORD_W-1:0] HASH_SEED = 64'd1469598103934665603;
  localparam logic [WORD_W-1:0] RECORD_MAGIC = 64'h5459434845505231;

  localparam logic [IDX_W-1:0] IDX_MAGIC = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_KIND = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_LENGTH = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_BODY = IDX_W'(3);

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_LEN   = 2'd1,
    STATUS_IDENT_BAD = 2'd2,
    STATUS_CSUM_BAD  = 2'd3
  } status_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] body_word;
    logic              body_valid;
    logic              record_end;
    logic [1:0]        status;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
    logic              body;
    logic              len_bad;
    logic              ident_bad;
  } cmd_t;

  // one fnv round multiply by 2^40 + 0x1b3, as shifts and adds
  function automatic logic [WORD_W-1:0] mul_prime(input logic [WORD_W-1:0] x);
    mul_prime = x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
  endfunction

endpackage

@@ rtl/frcc_queue.sv @@
module frcc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  frcc_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output frcc_pkg::cmd_t      head_cmd,
  output logic                empty,
  output logic                full
);

  frcc_pkg::cmd_t slot_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign empty    = (cnt_r == 2'd0);
  assign full     = (cnt_r == 2'd2);
  assign head_cmd = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ rtl/frcc_front.sv @@
module frcc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [7:0]          cfg_expected_kind,
  input  logic                in_valid,
  output logic                in_ready,
  input  frcc_pkg::in_item_t  in_item,
  input  logic                q_full,
  output logic                q_push,
  output frcc_pkg::cmd_t      q_cmd
);

  logic [frcc_pkg::KIND_W-1:0] kind_r;
  logic [frcc_pkg::IDX_W-1:0]  idx_r;
  logic [frcc_pkg::IDX_W-1:0]  idx_nxt;
  logic                        ovf_r;
  logic                        ovf_nxt;
  logic                        magic_ok_r;
  logic                        magic_ok_nxt;
  logic                        kind_ok_r;
  logic                        kind_ok_nxt;
  logic                        len_hi_zero_r;
  logic                        len_hi_zero_nxt;
  logic [frcc_pkg::IDX_W-1:0]  len_lo_r;
  logic [frcc_pkg::IDX_W-1:0]  len_lo_nxt;

  logic [frcc_pkg::IDX_W:0]    idx_plus1;
  logic                        ovf_now;
  logic                        short_rec;
  logic                        ident_ok;
  logic                        accept;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign q_push    = accept;

  assign idx_plus1 = {1'b0, idx_r} + (frcc_pkg::IDX_W+1)'(1);
  assign ovf_now   = ovf_r
                     || (idx_plus1 >= (frcc_pkg::IDX_W+1)'(frcc_pkg::MAX_RECORD_WORDS));
  assign short_rec = idx_plus1 < (frcc_pkg::IDX_W+1)'(frcc_pkg::MIN_RECORD_WORDS);
  assign ident_ok  = magic_ok_r && kind_ok_r && len_hi_zero_r
                     && (len_lo_r == (idx_r - frcc_pkg::IDX_BODY));

  always_comb begin
    q_cmd.word      = in_item.word;
    q_cmd.last      = in_item.last;
    q_cmd.body      = (idx_r >= frcc_pkg::IDX_BODY);
    q_cmd.len_bad   = short_rec || ovf_now;
    q_cmd.ident_bad = !ident_ok;
  end

  always_comb begin
    idx_nxt         = idx_r;
    ovf_nxt         = ovf_r;
    magic_ok_nxt    = magic_ok_r;
    kind_ok_nxt     = kind_ok_r;
    len_hi_zero_nxt = len_hi_zero_r;
    len_lo_nxt      = len_lo_r;
    if (accept) begin
      if (in_item.last) begin
        idx_nxt         = '0;
        ovf_nxt         = 1'b0;
        magic_ok_nxt    = 1'b0;
        kind_ok_nxt     = 1'b0;
        len_hi_zero_nxt = 1'b0;
        len_lo_nxt      = '0;
      end else begin
        ovf_nxt = ovf_now;
        if (idx_r < (frcc_pkg::IDX_W)'(frcc_pkg::MAX_RECORD_WORDS)) begin
          idx_nxt = idx_plus1[frcc_pkg::IDX_W-1:0];
        end
        case (idx_r)
          frcc_pkg::IDX_MAGIC: begin
            magic_ok_nxt = (in_item.word == frcc_pkg::RECORD_MAGIC);
          end
          frcc_pkg::IDX_KIND: begin
            kind_ok_nxt = (in_item.word
                           == {{(frcc_pkg::WORD_W-frcc_pkg::KIND_W){1'b0}}, kind_r});
          end
          frcc_pkg::IDX_LENGTH: begin
            len_hi_zero_nxt = (in_item.word[frcc_pkg::WORD_W-1:frcc_pkg::IDX_W] == '0);
            len_lo_nxt      = in_item.word[frcc_pkg::IDX_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r        <= '0;
      idx_r         <= '0;
      ovf_r         <= 1'b0;
      magic_ok_r    <= 1'b0;
      kind_ok_r     <= 1'b0;
      len_hi_zero_r <= 1'b0;
      len_lo_r      <= '0;
    end else begin
      if (cfg_valid) begin
        kind_r <= cfg_expected_kind;
      end
      idx_r         <= idx_nxt;
      ovf_r         <= ovf_nxt;
      magic_ok_r    <= magic_ok_nxt;
      kind_ok_r     <= kind_ok_nxt;
      len_hi_zero_r <= len_hi_zero_nxt;
      len_lo_r      <= len_lo_nxt;
    end
  end

endmodule

@@ rtl/frcc_back.sv @@
module frcc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  frcc_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output frcc_pkg::out_item_t out_item
);

  logic [frcc_pkg::WORD_W-1:0] hash_r;
  logic [frcc_pkg::WORD_W-1:0] hash_nxt;
  logic [frcc_pkg::WORD_W-1:0] held_word_r;
  logic [frcc_pkg::WORD_W-1:0] held_word_nxt;
  logic                        held_valid_r;
  logic                        held_valid_nxt;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  frcc_pkg::out_item_t         out_item_r;
  frcc_pkg::out_item_t         out_item_nxt;

  logic             emits;
  logic             out_free;
  frcc_pkg::status_t status;

  assign emits     = q_cmd.last || held_valid_r;
  assign out_free  = !out_valid_r || out_ready;
  assign q_pop     = !q_empty && (!emits || out_free);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    if (q_cmd.len_bad) begin
      status = frcc_pkg::STATUS_BAD_LEN;
    end else if (q_cmd.ident_bad) begin
      status = frcc_pkg::STATUS_IDENT_BAD;
    end else if (hash_r != q_cmd.word) begin
      status = frcc_pkg::STATUS_CSUM_BAD;
    end else begin
      status = frcc_pkg::STATUS_OK;
    end
  end

  always_comb begin
    hash_nxt       = hash_r;
    held_word_nxt  = held_word_r;
    held_valid_nxt = held_valid_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_item_nxt   = out_item_r;
    if (q_pop) begin
      if (emits) begin
        out_valid_nxt           = 1'b1;
        out_item_nxt.body_word  = held_valid_r ? held_word_r : '0;
        out_item_nxt.body_valid = held_valid_r;
        out_item_nxt.record_end = q_cmd.last;
        out_item_nxt.status     = q_cmd.last ? status : frcc_pkg::STATUS_OK;
      end
      if (q_cmd.last) begin
        hash_nxt       = frcc_pkg::HASH_SEED;
        held_word_nxt  = '0;
        held_valid_nxt = 1'b0;
      end else begin
        hash_nxt       = frcc_pkg::mul_prime(hash_r ^ q_cmd.word);
        held_word_nxt  = q_cmd.body ? q_cmd.word : '0;
        held_valid_nxt = q_cmd.body;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r       <= frcc_pkg::HASH_SEED;
      held_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      hash_r       <= hash_nxt;
      held_valid_r <= held_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_word_r <= held_word_nxt;
    out_item_r  <= out_item_nxt;
  end

endmodule

@@ rtl/framed_record_checksum_checker_core.sv @@
// framed record checker: checks magic, kind, length and fnv-style seal of a
// record streamed one 64-bit word per item, and forwards its body words.
// channels: in_valid/in_ready with in_item (word, last); out_valid/out_ready
// with out_item (body_word, body_valid, record_end, status); cfg_valid with
// cfg_expected_kind writes the record kind, cfg_ready is always high.
// each body word is held in the back stage and forwarded with the next item
// of the record; an accepted item passes the queue, then the output register.
// the item carrying last closes the record: record_end with the status, and
// possibly the last body word. throughput is one item per cycle while low
// out_ready does not hold the output, set by the hash round (xor, then
// multiply by the fnv prime as shifts and adds) in the back stage.
// a two-entry queue parts the classifying front from the hash stage, and
// the output register lets an item be accepted while a result waits.
// when out_ready is low and a result waits, items that give a result pile
// up in the queue and in_ready drops once two items wait in it.
// reset clears the record state, the kind register to zero and the queue.
module framed_record_checksum_checker_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_expected_kind,
  input  logic                in_valid,
  output logic                in_ready,
  input  frcc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output frcc_pkg::out_item_t out_item
);

  logic           q_full;
  logic           q_empty;
  logic           q_push;
  logic           q_pop;
  frcc_pkg::cmd_t push_cmd;
  frcc_pkg::cmd_t head_cmd;

  assign cfg_ready = 1'b1;

  frcc_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_expected_kind (cfg_expected_kind),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_item           (in_item),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_cmd             (push_cmd)
  );

  frcc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  frcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
